// File: rtl/uart_ring_buffer_pair_defines.svh
// Assertion macros for the UART ring buffer pair.
`ifndef UART_RING_BUFFER_PAIR_DEFINES_SVH
`define UART_RING_BUFFER_PAIR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off during reset.
`define URBP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("urbp assertion failed");
// Next-cycle implication, sampled on i_clk, off during reset.
`define URBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("urbp assertion failed");
`else
`define URBP_ASSERT_IMPL(lbl, ante, cons)
`define URBP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/urbp_pkg.sv
// Package: event codes and default depth for the UART ring buffer pair.
package urbp_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;

    typedef enum logic [1:0] {
        CMD_HOST_SEND = 2'd0,
        CMD_HOST_RECV = 2'd1,
        CMD_LINE_BYTE = 2'd2,
        CMD_LINE_DONE = 2'd3
    } t_cmd;

endpackage

// File: rtl/uart_ring_buffer_pair.sv
// UART transmit/receive ring buffer pair: event decode, two byte stores, result register.
// The result is registered: o_valid rises in the cycle after an input transfer.
// Throughput: one event per cycle while o_stall is low; the result register drains while the next event loads.
// The store reads are registered straight into the result register, one port per store.
// Reset (i_rst_n low, synchronous): pointers zero, transmitter idle, overflow clear,
// result register empty. Store contents are not cleared; no clearing pass is needed.
`include "uart_ring_buffer_pair_defines.svh"

module uart_ring_buffer_pair
    import urbp_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // event channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_tx_accepted,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_data,
    output logic       o_line_send_valid,
    output logic [7:0] o_line_send_data,
    output logic       o_rx_overflow
);

    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

    // Byte stores: one write and one read port each.
    logic [7:0] r_tx_mem [BUFFER_DEPTH];
    logic [7:0] r_rx_mem [BUFFER_DEPTH];

    // Control state
    logic [PTR_W-1:0] r_tx_wr, r_tx_rd, r_rx_wr, r_rx_rd;
    logic [PTR_W-1:0] n_tx_wr, n_tx_rd, n_rx_wr, n_rx_rd;
    logic             r_tx_idle, n_tx_idle;
    logic             r_overflow, n_overflow;
    logic             r_out_valid;

    // Result payload
    logic       r_tx_accepted, r_rx_valid, r_line_send_valid;
    logic [7:0] r_rx_data, r_line_send_data;

    // Decode outputs
    logic in_xfer;
    logic tx_we, rx_we;
    logic tx_send_now;   // host byte goes straight to the idle line
    logic tx_drain;      // line done, next stored byte goes out
    logic rx_pop;
    logic n_tx_accepted;

    logic [PTR_W-1:0] tx_wr_nx, tx_rd_nx, rx_wr_nx, rx_rd_nx;
    logic tx_full, tx_empty, rx_full, rx_empty;

    // Output register is free when empty or draining this cycle.
    assign o_stall = r_out_valid && i_stall;
    assign in_xfer = i_valid && !o_stall;

    // Pointer advance wraps at the depth, which need not be a power of two.
    assign tx_wr_nx = (r_tx_wr == PTR_LAST) ? '0 : r_tx_wr + 1'b1;
    assign tx_rd_nx = (r_tx_rd == PTR_LAST) ? '0 : r_tx_rd + 1'b1;
    assign rx_wr_nx = (r_rx_wr == PTR_LAST) ? '0 : r_rx_wr + 1'b1;
    assign rx_rd_nx = (r_rx_rd == PTR_LAST) ? '0 : r_rx_rd + 1'b1;

    // One slot is kept free so full and empty stay distinct.
    assign tx_full  = (tx_wr_nx == r_tx_rd);
    assign tx_empty = (r_tx_wr == r_tx_rd);
    assign rx_full  = (rx_wr_nx == r_rx_rd);
    assign rx_empty = (r_rx_wr == r_rx_rd);

    always_comb begin
        n_tx_wr       = r_tx_wr;
        n_tx_rd       = r_tx_rd;
        n_rx_wr       = r_rx_wr;
        n_rx_rd       = r_rx_rd;
        n_tx_idle     = r_tx_idle;
        n_overflow    = r_overflow;
        n_tx_accepted = 1'b0;
        tx_we         = 1'b0;
        rx_we         = 1'b0;
        tx_send_now   = 1'b0;
        tx_drain      = 1'b0;
        rx_pop        = 1'b0;
        if (in_xfer) begin
            case (t_cmd'(i_cmd))
                CMD_HOST_SEND: begin
                    // A full store refuses the byte even with the line idle.
                    if (!tx_full) begin
                        tx_we         = 1'b1;
                        n_tx_accepted = 1'b1;
                        n_tx_idle     = 1'b0;
                        if (r_tx_idle) begin
                            // written but not queued: the pointer stays put
                            tx_send_now = 1'b1;
                        end else begin
                            n_tx_wr = tx_wr_nx;
                        end
                    end
                end
                CMD_HOST_RECV: begin
                    if (!rx_empty) begin
                        rx_pop  = 1'b1;
                        n_rx_rd = rx_rd_nx;
                    end
                end
                CMD_LINE_BYTE: begin
                    if (rx_full) begin
                        n_overflow = 1'b1;
                    end else begin
                        rx_we   = 1'b1;
                        n_rx_wr = rx_wr_nx;
                    end
                end
                CMD_LINE_DONE: begin
                    if (!tx_empty) begin
                        tx_drain  = 1'b1;
                        n_tx_rd   = tx_rd_nx;
                        n_tx_idle = 1'b0;
                    end else begin
                        n_tx_idle = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_wr     <= '0;
            r_tx_rd     <= '0;
            r_rx_wr     <= '0;
            r_rx_rd     <= '0;
            r_tx_idle   <= 1'b1;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tx_wr    <= n_tx_wr;
            r_tx_rd    <= n_tx_rd;
            r_rx_wr    <= n_rx_wr;
            r_rx_rd    <= n_rx_rd;
            r_tx_idle  <= n_tx_idle;
            r_overflow <= n_overflow;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Store writes
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[r_tx_wr] <= i_data;
        end
        if (rx_we) begin
            r_rx_mem[r_rx_wr] <= i_data;
        end
    end

    // Result register; store reads land here directly. Unused fields read zero.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_tx_accepted     <= n_tx_accepted;
            r_rx_valid        <= rx_pop;
            r_rx_data         <= rx_pop ? r_rx_mem[r_rx_rd] : 8'd0;
            r_line_send_valid <= tx_send_now || tx_drain;
            if (tx_send_now) begin
                r_line_send_data <= i_data;
            end else if (tx_drain) begin
                r_line_send_data <= r_tx_mem[r_tx_rd];
            end else begin
                r_line_send_data <= 8'd0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_tx_accepted     = r_tx_accepted;
    assign o_rx_valid        = r_rx_valid;
    assign o_rx_data         = r_rx_data;
    assign o_line_send_valid = r_line_send_valid;
    assign o_line_send_data  = r_line_send_data;
    // flag changes only when a result is loaded, so it is the value after that event
    assign o_rx_overflow     = r_overflow;

    // Assertions
    `URBP_ASSERT_NEXT(a_overflow_sticky, r_overflow, r_overflow)
    `URBP_ASSERT_IMPL(a_rx_excl, o_valid && o_rx_valid, !o_line_send_valid && !o_tx_accepted)
    `URBP_ASSERT_NEXT(a_drain_empty_idles, in_xfer && tx_empty && (i_cmd == CMD_LINE_DONE), r_tx_idle)
    `URBP_ASSERT_NEXT(a_send_busy, tx_we, !r_tx_idle && o_valid && o_tx_accepted)

endmodule
